// ----- rtl/sst_pkg.sv -----
// Shared types and constants for the space separated tokenizer.
// Holds the token kind codes and the result transaction layout.
// No dependencies.
package sst_pkg;

  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned IDENT_BYTES     = 8;
  localparam int unsigned IDENT_CNT_W     = 4;
  localparam int unsigned NUM_W           = 31;
  localparam int unsigned KIND_W          = 4;
  localparam int unsigned MAX_IDENT_CHARS = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER    = 4'd0,
    KIND_IDENT     = 4'd1,
    KIND_ECHO      = 4'd2,
    KIND_PLUS      = 4'd3,
    KIND_EQUALS    = 4'd4,
    KIND_END_OK    = 4'd5,
    KIND_MIXED_ERR = 4'd6,
    KIND_UNK_ERR   = 4'd7,
    KIND_NO_TOKEN  = 4'd8,
    KIND_IDENT_LONG = 4'd9
  } kind_e;

  typedef struct packed {
    kind_e                            kind;
    logic [NUM_W-1:0]                 number_value;
    logic [IDENT_BYTES*CHAR_W-1:0]    ident_text;
    logic [IDENT_CNT_W-1:0]           ident_length;
  } sst_result_t;

endpackage

// ----- rtl/sst_scan.sv -----
// Byte scanner for the space separated tokenizer: scan mode, number
// accumulator, identifier buffer and token flag, updated once per byte.
// Depends on sst_pkg.
module sst_scan
  import sst_pkg::*;
#(
  parameter int unsigned MAX_IDENT_CHARS = sst_pkg::MAX_IDENT_CHARS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [CHAR_W-1:0]   ch_i,
  output logic                res_valid_o,
  output sst_result_t         res_o
);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_SKIP  = 2'd3;

  localparam logic [CHAR_W-1:0] CharEnd     = 8'h00;
  localparam logic [CHAR_W-1:0] CharZero    = "0";
  localparam logic [CHAR_W-1:0] CharNine    = "9";
  localparam logic [CHAR_W-1:0] CharLowA    = "a";
  localparam logic [CHAR_W-1:0] CharLowZ    = "z";
  localparam logic [CHAR_W-1:0] CharUpA     = "A";
  localparam logic [CHAR_W-1:0] CharUpZ     = "Z";
  localparam logic [CHAR_W-1:0] CharUscore  = "_";
  localparam logic [CHAR_W-1:0] CharSpace   = " ";
  localparam logic [CHAR_W-1:0] CharNewline = 8'h0A;
  localparam logic [CHAR_W-1:0] CharPlus    = "+";
  localparam logic [CHAR_W-1:0] CharEquals  = "=";
  // "echo" with the first character in the lowest byte
  localparam logic [4*CHAR_W-1:0] EchoText  = "ohce";

  localparam int unsigned          ProdW   = NUM_W + 4;
  localparam logic [ProdW-1:0]     NumMax  = {4'd0, {NUM_W{1'b1}}};
  localparam logic [IDENT_CNT_W-1:0] MaxCnt  = IDENT_CNT_W'(MAX_IDENT_CHARS);
  localparam logic [IDENT_CNT_W-1:0] OvflCnt = IDENT_CNT_W'(MAX_IDENT_CHARS + 1);
  localparam logic [IDENT_CNT_W-1:0] EchoLen = IDENT_CNT_W'(4);

  logic [1:0]                          mode_q, mode_d;
  logic                                seen_q, seen_d;
  logic [IDENT_CNT_W-1:0]              cnt_q, cnt_d;
  logic [NUM_W-1:0]                    acc_q, acc_d;
  logic [IDENT_BYTES-1:0][CHAR_W-1:0]  buf_q, buf_d;

  logic             is_digit, is_letter, is_blank;
  logic [CHAR_W-1:0] ch_off;
  logic [ProdW-1:0] prod;
  logic [NUM_W-1:0] acc_next;
  logic             cnt_ovfl;
  sst_result_t      res;
  logic             res_valid;

  assign is_digit  = (ch_i >= CharZero) && (ch_i <= CharNine);
  assign is_letter = ((ch_i >= CharLowA) && (ch_i <= CharLowZ)) ||
                     ((ch_i >= CharUpA) && (ch_i <= CharUpZ)) || (ch_i == CharUscore);
  assign is_blank  = (ch_i == CharSpace) || (ch_i == CharNewline);
  assign ch_off    = ch_i - CharZero;

  // acc * 10 + digit as two shifts and two adds, then saturate
  assign prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + ProdW'(ch_off[3:0]);
  assign acc_next = (prod > NumMax) ? NumMax[NUM_W-1:0] : prod[NUM_W-1:0];
  assign cnt_ovfl = (cnt_q > MaxCnt);

  always_comb begin
    mode_d    = mode_q;
    seen_d    = seen_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    buf_d     = buf_q;
    res_valid = 1'b0;
    res       = '0;
    case (mode_q)
      MODE_SKIP: begin
        if (ch_i == CharEnd) begin
          mode_d = MODE_START;
          seen_d = 1'b0;
          cnt_d  = '0;
        end
      end
      MODE_NUM: begin
        if (is_digit) begin
          acc_d = acc_next;
        end else if (is_blank) begin
          res_valid        = 1'b1;
          res.kind         = KIND_NUMBER;
          res.number_value = acc_q;
          mode_d           = MODE_START;
          seen_d           = 1'b1;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_MIXED_ERR;
          if (ch_i == CharEnd) begin
            mode_d = MODE_START;
            seen_d = 1'b0;
          end else begin
            mode_d = MODE_SKIP;
          end
        end
      end
      MODE_IDENT: begin
        if (is_letter || is_digit) begin
          if (cnt_q < MaxCnt) begin
            buf_d[cnt_q[2:0]] = ch_i;
            cnt_d             = cnt_q + IDENT_CNT_W'(1);
          end else begin
            cnt_d = OvflCnt;
          end
        end else if (is_blank) begin
          res_valid = 1'b1;
          mode_d    = MODE_START;
          seen_d    = 1'b1;
          cnt_d     = '0;
          if (cnt_ovfl) begin
            res.kind         = KIND_IDENT_LONG;
            res.ident_text   = buf_q;
            res.ident_length = MaxCnt;
          end else if ((cnt_q == EchoLen) && (buf_q[3:0] == EchoText)) begin
            res.kind = KIND_ECHO;
          end else begin
            res.kind         = KIND_IDENT;
            res.ident_text   = buf_q;
            res.ident_length = cnt_q;
          end
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_MIXED_ERR;
          cnt_d     = '0;
          if (ch_i == CharEnd) begin
            mode_d = MODE_START;
            seen_d = 1'b0;
          end else begin
            mode_d = MODE_SKIP;
          end
        end
      end
      default: begin
        if (is_digit) begin
          acc_d  = NUM_W'(ch_off[3:0]);
          mode_d = MODE_NUM;
        end else if (is_letter) begin
          // start a fresh word: clear the buffer so unused bytes read zero
          buf_d    = '0;
          buf_d[0] = ch_i;
          cnt_d    = IDENT_CNT_W'(1);
          mode_d   = MODE_IDENT;
        end else if (is_blank) begin
          mode_d = MODE_START;
        end else if (ch_i == CharPlus) begin
          res_valid = 1'b1;
          res.kind  = KIND_PLUS;
          seen_d    = 1'b1;
        end else if (ch_i == CharEquals) begin
          res_valid = 1'b1;
          res.kind  = KIND_EQUALS;
          seen_d    = 1'b1;
        end else if (ch_i == CharEnd) begin
          res_valid = 1'b1;
          res.kind  = seen_q ? KIND_END_OK : KIND_NO_TOKEN;
          seen_d    = 1'b0;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_UNK_ERR;
          mode_d    = MODE_SKIP;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      seen_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      seen_q <= seen_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      acc_q <= acc_d;
      buf_q <= buf_d;
    end
  end

  assign res_valid_o = accept_i && res_valid;
  assign res_o       = res;

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OvflCnt)
    else $error("identifier count past overflow mark");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SKIP) |-> !res_valid)
    else $error("result produced while skipping");

  a_start_after_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_blank && (mode_q != MODE_SKIP)) |=> (mode_q == MODE_START))
    else $error("blank did not return scanner to start mode");

endmodule

// ----- rtl/space_separated_tokenizer_top.sv -----
// A result is registered in the output stage before it leaves on out_*.
// Throughput: one byte per cycle unless stalled; the scanner updates its state
// in a single pass, and a two-entry output stage (result register plus skid
// register) asserts in_stall_o only when both entries hold untaken results.
// Reset: rst_ni (async, active low) puts the scanner in start mode with no
// token seen and empties the output stage.
module space_separated_tokenizer_top
  import sst_pkg::*;
#(
  parameter int unsigned MAX_IDENT_CHARS = sst_pkg::MAX_IDENT_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CHAR_W-1:0]             ch_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [KIND_W-1:0]             kind_o,
  output logic [NUM_W-1:0]              number_value_o,
  output logic [IDENT_BYTES*CHAR_W-1:0] ident_text_o,
  output logic [IDENT_CNT_W-1:0]        ident_length_o
);

  logic        accept;
  logic        res_valid;
  sst_result_t res;
  logic        out_valid_q, skid_valid_q;
  sst_result_t out_q, skid_q;
  logic        out_take;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  sst_scan #(
    .MAX_IDENT_CHARS (MAX_IDENT_CHARS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ch_i        (ch_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign number_value_o = out_q.number_value;
  assign ident_text_o   = out_q.ident_text;
  assign ident_length_o = out_q.ident_length;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_held_result_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid entry lost while output stalled");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the space separated tokenizer top level.
// Drives text bytes under random bursts and output stalls, predicts non-fixed
// tokens in a behavioral scanner, checks each result transaction; needs sst_pkg.
module tb_top;
  import sst_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BYTES   = 440;
  localparam int PRINT_LIMIT    = 40;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_US    = 8'h5F;

  localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};
  // first character sits in the lowest byte
  localparam logic [31:0] ECHO_TEXT = {"o", "h", "c", "e"};

  typedef enum logic [1:0] {SCAN_START, SCAN_NUM, SCAN_IDENT, SCAN_SKIP} scan_mode_e;

  typedef struct packed {
    logic [7:0]  ch;
    logic        fixed;
    sst_result_t res;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fixed;
    kind_e      kind;
  } dir_row_t;

  // Rows with fixed set carry a result that needs no prediction.
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{CH_END,   1'b1, KIND_NO_TOKEN},
    '{CH_PLUS,  1'b1, KIND_PLUS},
    '{CH_EQ,    1'b1, KIND_EQUALS},
    '{"e",      1'b0, KIND_NUMBER},
    '{"c",      1'b0, KIND_NUMBER},
    '{"h",      1'b0, KIND_NUMBER},
    '{"o",      1'b0, KIND_NUMBER},
    '{CH_SPACE, 1'b1, KIND_ECHO},
    '{CH_END,   1'b1, KIND_END_OK},
    '{"1",      1'b0, KIND_NUMBER},
    '{"a",      1'b1, KIND_MIXED_ERR},
    '{CH_PLUS,  1'b0, KIND_NUMBER},
    '{CH_END,   1'b0, KIND_NUMBER},
    '{8'hFF,    1'b1, KIND_UNK_ERR},
    '{CH_END,   1'b0, KIND_NUMBER},
    '{CH_US,    1'b0, KIND_NUMBER},
    '{"Z",      1'b0, KIND_NUMBER},
    '{"9",      1'b0, KIND_NUMBER},
    '{CH_NL,    1'b0, KIND_NUMBER},
    '{"7",      1'b0, KIND_NUMBER},
    '{CH_END,   1'b1, KIND_MIXED_ERR},
    '{"q",      1'b0, KIND_NUMBER},
    '{CH_END,   1'b1, KIND_MIXED_ERR},
    '{CH_END,   1'b1, KIND_NO_TOKEN},
    '{CH_NL,    1'b0, KIND_NUMBER},
    '{8'h80,    1'b1, KIND_UNK_ERR}
  };

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic [CHAR_W-1:0]             ch_i           = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic [KIND_W-1:0]             kind_o;
  logic [NUM_W-1:0]              number_value_o;
  logic [IDENT_BYTES*CHAR_W-1:0] ident_text_o;
  logic [IDENT_CNT_W-1:0]        ident_length_o;

  text_item_t  text_bytes[$];
  sst_result_t pending_tokens[$];
  text_item_t  cur_item = '0;

  bit stim_go     = 1'b0;
  int err_count   = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  // scanner state of the predictor
  scan_mode_e                    scan_mode;
  logic [NUM_W-1:0]              num_acc;
  logic [IDENT_BYTES*CHAR_W-1:0] id_buf;
  logic [IDENT_CNT_W-1:0]        id_cnt;
  logic                          tok_seen;

  space_separated_tokenizer_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .number_value_o (number_value_o),
    .ident_text_o   (ident_text_o),
    .ident_length_o (ident_length_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_NL;
  endfunction

  task automatic clear_word();
    num_acc = '0;
    id_buf  = '0;
    id_cnt  = '0;
  endtask

  task automatic rearm_scanner();
    clear_word();
    scan_mode = SCAN_START;
    tok_seen  = 1'b0;
  endtask

  task automatic take_ident_char(input logic [7:0] c);
    if (id_cnt < MAX_IDENT_CHARS) begin
      id_buf[8*id_cnt[2:0] +: 8] = c;
      id_cnt++;
    end else begin
      id_cnt = 4'(MAX_IDENT_CHARS + 1);
    end
  endtask

  // Advance the predictor by one byte; hit tells whether a token leaves.
  task automatic scan_byte(input logic [7:0] c, output logic hit, output sst_result_t res);
    longint unsigned v;
    begin
      hit = 1'b0;
      res = '0;
      case (scan_mode)
        SCAN_SKIP: begin
          if (c == CH_END) rearm_scanner();
        end
        SCAN_NUM: begin
          if (is_digit(c)) begin
            v = longint'(num_acc) * 10 + longint'(c - CH_ZERO);
            num_acc = (v > longint'(NUM_SAT)) ? NUM_SAT : v[NUM_W-1:0];
          end else if (is_blank(c)) begin
            hit = 1'b1;
            res.kind = KIND_NUMBER;
            res.number_value = num_acc;
            clear_word();
            scan_mode = SCAN_START;
            tok_seen  = 1'b1;
          end else begin
            hit = 1'b1;
            res.kind = KIND_MIXED_ERR;
            if (c == CH_END) rearm_scanner();
            else scan_mode = SCAN_SKIP;
          end
        end
        SCAN_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            take_ident_char(c);
          end else if (is_blank(c)) begin
            hit = 1'b1;
            if (id_cnt > MAX_IDENT_CHARS) begin
              res.kind = KIND_IDENT_LONG;
              res.ident_length = 4'(MAX_IDENT_CHARS);
            end else begin
              res.kind = KIND_IDENT;
              res.ident_length = id_cnt;
            end
            res.ident_text = id_buf;
            if (res.kind == KIND_IDENT && id_cnt == 4 && id_buf[31:0] == ECHO_TEXT) begin
              res.kind = KIND_ECHO;
              res.ident_text = '0;
              res.ident_length = '0;
            end
            clear_word();
            scan_mode = SCAN_START;
            tok_seen  = 1'b1;
          end else begin
            hit = 1'b1;
            res.kind = KIND_MIXED_ERR;
            if (c == CH_END) rearm_scanner();
            else scan_mode = SCAN_SKIP;
          end
        end
        default: begin
          if (is_digit(c)) begin
            clear_word();
            num_acc = NUM_W'(c - CH_ZERO);
            scan_mode = SCAN_NUM;
          end else if (is_letter(c)) begin
            clear_word();
            take_ident_char(c);
            scan_mode = SCAN_IDENT;
          end else if (is_blank(c)) begin
            hit = 1'b0;
          end else if (c == CH_PLUS) begin
            hit = 1'b1;
            res.kind = KIND_PLUS;
            tok_seen = 1'b1;
          end else if (c == CH_EQ) begin
            hit = 1'b1;
            res.kind = KIND_EQUALS;
            tok_seen = 1'b1;
          end else if (c == CH_END) begin
            hit = 1'b1;
            res.kind = tok_seen ? KIND_END_OK : KIND_NO_TOKEN;
            rearm_scanner();
          end else begin
            hit = 1'b1;
            res.kind = KIND_UNK_ERR;
            scan_mode = SCAN_SKIP;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] c);
    text_item_t it;
    begin
      it = '0;
      it.ch = c;
      text_bytes.push_back(it);
    end
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic put_blanks();
    int n;
    begin
      n = ($urandom_range(0, 3) == 0) ? 2 : 1;
      repeat (n) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_NL);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    begin
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return CH_US;
    end
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 5) == 0) return 8'(CH_ZERO + $urandom_range(0, 9));
    return rand_letter();
  endfunction

  task automatic put_number();
    int n;
    begin
      case ($urandom_range(0, 9))
        0: put_string("2147483647");
        1: put_string("2147483648");
        2, 3: begin
          n = $urandom_range(9, 12);
          repeat (n) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
      endcase
    end
  endtask

  task automatic put_ident();
    int n;
    begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(7, 12);
      push_byte(rand_letter());
      repeat (n - 1) push_byte(rand_word_char());
    end
  endtask

  task automatic put_echo_like();
    case ($urandom_range(0, 5))
      0, 1: put_string("echo");
      2: put_string("ech");
      3: put_string("echoo");
      4: put_string("Echo");
      default: put_string("echo9");
    endcase
  endtask

  // Emit one number or identifier word, no separator.
  task automatic put_word();
    case ($urandom_range(0, 6))
      0, 1, 2: put_number();
      3, 4, 5: put_ident();
      default: put_echo_like();
    endcase
  endtask

  task automatic put_token();
    case ($urandom_range(0, 9))
      8: begin
        push_byte(CH_PLUS);
        if ($urandom_range(0, 1)) put_blanks();
      end
      9: begin
        push_byte(CH_EQ);
        if ($urandom_range(0, 1)) put_blanks();
      end
      default: begin
        put_word();
        put_blanks();
      end
    endcase
  endtask

  // One text: mostly well-formed tokens, sometimes with a fault inside.
  task automatic gen_text();
    int ntok, fault_at;
    begin
      ntok = $urandom_range(0, 6);
      fault_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ntok) : -1;
      if ($urandom_range(0, 1)) put_blanks();
      for (int t = 0; t <= ntok; t++) begin
        if (t == fault_at) begin
          case ($urandom_range(0, 2))
            0: push_byte(8'($urandom_range(1, 255)));
            1: begin
              put_word();
              push_byte(8'($urandom_range(1, 255)));
            end
            default: begin
              // end of text inside a word
              put_word();
              break;
            end
          endcase
        end
        if (t < ntok) put_token();
      end
      push_byte(CH_END);
    end
  endtask

  // ------------------------------------------------------------------ sender
  always @(posedge clk_i) begin : sender
    logic       nxt_valid;
    text_item_t nxt_item;
    if (rst_ni && stim_go) begin
      nxt_valid = in_valid_i;
      nxt_item  = cur_item;
      if (in_valid_i && !in_stall_o) begin
        nxt_valid = 1'b0;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 40);
        end
      end
      if (!nxt_valid && text_bytes.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt_item  = text_bytes.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) burst_left--;
        end
      end
      in_valid_i <= nxt_valid;
      cur_item   <= nxt_item;
      ch_i       <= nxt_item.ch;
    end
  end

  // ---------------------------------------------------------- receiver stall
  always @(posedge clk_i) begin : receiver
    logic nxt_stall;
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: nxt_stall = 1'b0;
        1: nxt_stall = $urandom_range(0, 1);
        default: nxt_stall = ($urandom_range(0, 3) != 0);
      endcase
      out_stall_i <= nxt_stall;
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : monitor
    sst_result_t want;
    logic        hit;
    logic        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("result transaction with nothing expected, kind %0d",
                                    kind_o));
        end else begin
          want = pending_tokens.pop_front();
          if (kind_o !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", kind_o, want.kind));
          if (number_value_o !== want.number_value)
            report_mismatch($sformatf("number_value got %0d want %0d",
                                      number_value_o, want.number_value));
          if (ident_text_o !== want.ident_text)
            report_mismatch($sformatf("ident_text got %h want %h",
                                      ident_text_o, want.ident_text));
          if (ident_length_o !== want.ident_length)
            report_mismatch($sformatf("ident_length got %0d want %0d",
                                      ident_length_o, want.ident_length));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        scan_byte(ch_i, hit, want);
        if (cur_item.fixed) pending_tokens.push_back(cur_item.res);
        else if (hit) pending_tokens.push_back(want);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------- main
  initial begin : main
    text_item_t it;
    bit         timed_out;
    timed_out = 1'b0;
    rearm_scanner();
    foreach (DIRECTED_ROWS[i]) begin
      it = '0;
      it.ch    = DIRECTED_ROWS[i].ch;
      it.fixed = DIRECTED_ROWS[i].fixed;
      it.res.kind = DIRECTED_ROWS[i].kind;
      text_bytes.push_back(it);
    end
    while (text_bytes.size() < $size(DIRECTED_ROWS) + RANDOM_BYTES) gen_text();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    stim_go = 1'b1;

    while (!timed_out &&
           !(text_bytes.size() == 0 && !in_valid_i && pending_tokens.size() == 0)) begin
      @(negedge clk_i);
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk_i);
    end
    if (pending_tokens.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_tokens.size()));

    if (!timed_out && err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sst_pkg.sv
rtl/sst_scan.sv
rtl/space_separated_tokenizer_top.sv
test/tb_top.sv
